/* src/jfss_pkg.sv */
// ----------------------------------------------------------------------------
// jfss_pkg
// Shared types and constants for the JPEG frame size scanner.
// ----------------------------------------------------------------------------
package jfss_pkg;

  // Width of the byte position counter and of the frame length field.
  localparam int unsigned POS_W = 24;

  // Marker and header byte codes.
  localparam logic [7:0] BYTE_FILL = 8'hFF;
  localparam logic [7:0] MRK_SOI   = 8'hD8;
  localparam logic [7:0] MRK_EOI   = 8'hD9;
  localparam logic [7:0] MRK_RST0  = 8'hD0;
  localparam logic [7:0] MRK_RST7  = 8'hD7;
  localparam logic [7:0] MRK_TEM   = 8'h01;
  localparam logic [7:0] MRK_SOF0  = 8'hC0;

  // Smallest frame length that may hold a start-of-frame segment, minus one.
  localparam logic [POS_W-1:0] MIN_LEN_M1 = POS_W'(8);
  // Distance from a marker to the frame end at or below which the scan gives up.
  localparam logic [POS_W:0]   MARK_GUARD = (POS_W + 1)'(7);

  typedef enum logic [3:0] {
    PH_HDR0,
    PH_HDR1,
    PH_MARK,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_SOF_LEN_HI,
    PH_SOF_LEN_LO,
    PH_SOF_PREC,
    PH_H_HI,
    PH_H_LO,
    PH_W_HI,
    PH_W_LO,
    PH_HALT
  } phase_t;

  // Result of one frame, handed from the parser to the output stage.
  typedef struct packed {
    logic        found;
    logic [15:0] pic_width;
    logic [15:0] pic_height;
  } frame_res_t;

endpackage

/* src/jpeg_frame_size_scanner.sv */
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// Finds the baseline start-of-frame segment of a JPEG frame and reports
// the picture width and height once per frame.
// ----------------------------------------------------------------------------
// Output: the result is registered in the output register in the cycle after the
// frame's last word is accepted.
// Throughput: one word per cycle; the input stalls only while a result
// waits in the output register and the output is not ready.
// Reset: synchronous, active low; clears the parse state and the output valid.
module jpeg_frame_size_scanner
  import jfss_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic [POS_W-1:0] in_frame_length,
  input  logic             in_last_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_found,
  output logic [15:0]      out_pic_width,
  output logic [15:0]      out_pic_height
);

  logic       step;
  frame_res_t res;
  logic       out_valid_r;
  frame_res_t out_res_r;

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  jfss_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .data_byte    (in_data_byte),
    .frame_length (in_frame_length),
    .last_byte    (in_last_byte),
    .res          (res)
  );

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (step && in_last_byte) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_res_r.found;
  assign out_pic_width  = out_res_r.pic_width;
  assign out_pic_height = out_res_r.pic_height;

endmodule

/* src/jfss_parser.sv */
// ----------------------------------------------------------------------------
// jfss_parser
// Marker walker: updates the parse phase on each accepted word and
// presents the frame result that holds after the current word.
// ----------------------------------------------------------------------------
module jfss_parser
  import jfss_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic [POS_W-1:0] frame_length,
  input  logic             last_byte,
  output frame_res_t       res
);

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      skip_r, skip_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [15:0]      height_r, height_nxt;
  logic [15:0]      width_r, width_nxt;
  logic             found_r, found_nxt;

  logic [15:0]      seg_len;
  logic             past_end;
  logic             near_end;
  logic             no_len_mrk;

  assign seg_len    = {len_hi_r, data_byte};
  assign past_end   = (pos_r >= frame_length);
  assign near_end   = (({1'b0, pos_r} + MARK_GUARD) >= {1'b0, frame_length});
  assign no_len_mrk = (data_byte == MRK_SOI) || (data_byte == MRK_TEM) ||
                      ((data_byte >= MRK_RST0) && (data_byte <= MRK_RST7));

  // Next phase and captured fields for the current word.
  always_comb begin
    phase_nxt  = phase_r;
    skip_nxt   = skip_r;
    len_hi_nxt = len_hi_r;
    height_nxt = height_r;
    width_nxt  = width_r;
    found_nxt  = found_r;
    unique case (phase_r)
      PH_HDR0: begin
        phase_nxt = (data_byte == BYTE_FILL) ? PH_HDR1 : PH_HALT;
      end
      PH_HDR1: begin
        phase_nxt = ((data_byte == MRK_SOI) && (frame_length > MIN_LEN_M1)) ?
                    PH_MARK : PH_HALT;
      end
      PH_MARK: begin
        if (past_end) begin
          phase_nxt = PH_HALT;
        end else if (data_byte == BYTE_FILL) begin
          phase_nxt = PH_MARK;
        end else if (near_end) begin
          phase_nxt = PH_HALT;
        end else if (no_len_mrk) begin
          phase_nxt = PH_MARK;
        end else if (data_byte == MRK_EOI) begin
          phase_nxt = PH_HALT;
        end else begin
          phase_nxt = (data_byte == MRK_SOF0) ? PH_SOF_LEN_HI : PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_hi_nxt = data_byte;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len < 16'd2) begin
          phase_nxt = PH_HALT;
        end else if (seg_len == 16'd2) begin
          phase_nxt = PH_MARK;
        end else begin
          skip_nxt  = seg_len - 16'd2;
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) begin
          phase_nxt = PH_MARK;
        end
      end
      PH_SOF_LEN_HI: begin
        len_hi_nxt = data_byte;
        phase_nxt  = PH_SOF_LEN_LO;
      end
      PH_SOF_LEN_LO: phase_nxt = PH_SOF_PREC;
      PH_SOF_PREC:   phase_nxt = PH_H_HI;
      PH_H_HI: begin
        height_nxt = {data_byte, 8'h00};
        phase_nxt  = PH_H_LO;
      end
      PH_H_LO: begin
        height_nxt = {height_r[15:8], data_byte};
        phase_nxt  = PH_W_HI;
      end
      PH_W_HI: begin
        width_nxt = {data_byte, 8'h00};
        phase_nxt = PH_W_LO;
      end
      PH_W_LO: begin
        width_nxt = {width_r[15:8], data_byte};
        found_nxt = 1'b1;
        phase_nxt = PH_HALT;
      end
      default: phase_nxt = PH_HALT;
    endcase
  end

  // Byte position saturates at all ones.
  assign pos_nxt = (&pos_r) ? pos_r : pos_r + POS_W'(1);

  // Result after this word; only meaningful with last_byte.
  assign res.found      = found_nxt;
  assign res.pic_width  = found_nxt ? width_nxt : 16'd0;
  assign res.pic_height = found_nxt ? height_nxt : 16'd0;

  // Control state; a frame's last word returns it to the reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      pos_r   <= '0;
      found_r <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        phase_r <= PH_HDR0;
        pos_r   <= '0;
        found_r <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        found_r <= found_nxt;
      end
    end
  end

  // Captured fields are always written before they are used.
  always_ff @(posedge clk) begin
    if (step) begin
      skip_r   <= skip_nxt;
      len_hi_r <= len_hi_nxt;
      height_r <= height_nxt;
      width_r  <= width_nxt;
    end
  end

endmodule
